// File: rtl/core/spf8_pkg.sv
// ----------------------------------------------------------------------------
// spf8_pkg: shared types and constants of the 8-tap sub-pel interpolator
// Field widths, arithmetic widths, parameter defaults and the pixel clip.
// ----------------------------------------------------------------------------
package spf8_pkg;

   localparam int NUM_TAPS  = 8;
   localparam int TAP_W     = 16;
   localparam int COEF_W    = 9;
   localparam int OUT_W     = 16;
   localparam int CSR_IDX_W = 3;
   localparam int PIX_BITS  = 8;
   localparam int PIX_MAX   = 255;

   // product, 8-term sum, and working width with headroom for offsets and shifts
   localparam int PROD_W = TAP_W + COEF_W;
   localparam int ACC_W  = PROD_W + 3;
   localparam int SUM_W  = ACC_W + 2;

   localparam int FILTER_PREC_DEF   = 6;
   localparam int INTERNAL_PREC_DEF = 14;

   typedef logic signed [TAP_W-1:0]  tap_type;
   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic signed [OUT_W-1:0]  out_type;
   typedef logic signed [ACC_W-1:0]  acc_type;
   typedef logic signed [SUM_W-1:0]  sum_type;

   typedef tap_type  tap_arr_type  [NUM_TAPS];
   typedef coef_type coef_arr_type [NUM_TAPS];

   typedef struct packed {
      logic is_first;
      logic is_last;
      logic bypass;
   } flags_type;

   function automatic out_type clip_pix(input sum_type v);
      out_type r;
      if (v < 0) begin
         r = '0;
      end else if (v > sum_type'(PIX_MAX)) begin
         r = out_type'(PIX_MAX);
      end else begin
         r = v[OUT_W-1:0];
      end
      return r;
   endfunction

endpackage

// File: rtl/core/spf8_intf.sv
// ----------------------------------------------------------------------------
// spf8 channel interfaces
// Request, response and register-write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface spf8_req_intf;
   logic               valid;
   logic               ready;
   spf8_pkg::tap_type  tap_0;
   spf8_pkg::tap_type  tap_1;
   spf8_pkg::tap_type  tap_2;
   spf8_pkg::tap_type  tap_3;
   spf8_pkg::tap_type  tap_4;
   spf8_pkg::tap_type  tap_5;
   spf8_pkg::tap_type  tap_6;
   spf8_pkg::tap_type  tap_7;
   logic               is_first;
   logic               is_last;
   logic               bypass;

   modport source (output valid, tap_0, tap_1, tap_2, tap_3, tap_4, tap_5, tap_6, tap_7,
                   is_first, is_last, bypass, input ready);
   modport sink   (input valid, tap_0, tap_1, tap_2, tap_3, tap_4, tap_5, tap_6, tap_7,
                   is_first, is_last, bypass, output ready);
endinterface

interface spf8_rsp_intf;
   logic               valid;
   logic               ready;
   spf8_pkg::out_type  filtered;

   modport source (output valid, filtered, input ready);
   modport sink   (input valid, filtered, output ready);
endinterface

interface spf8_csr_intf;
   logic                             valid;
   logic                             ready;
   logic [spf8_pkg::CSR_IDX_W-1:0]   index;
   spf8_pkg::coef_type               data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/spf8_csr.sv
// ----------------------------------------------------------------------------
// spf8_csr: coefficient register file
// Eight signed filter coefficients, written one at a time, cleared by reset.
// ----------------------------------------------------------------------------
module spf8_csr (
   input  logic                   clock,
   input  logic                   reset,
   spf8_csr_intf.sink             csr_port,
   output spf8_pkg::coef_arr_type coef
);

   spf8_pkg::coef_arr_type coef_ff;

   assign csr_port.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < spf8_pkg::NUM_TAPS; i++) begin
            coef_ff[i] <= '0;
         end
      end else if (csr_port.valid) begin
         coef_ff[csr_port.index] <= csr_port.data;
      end
   end

   assign coef = coef_ff;

endmodule

// File: rtl/core/spf8_dot.sv
// ----------------------------------------------------------------------------
// spf8_dot: 8-tap dot product
// Signed products of samples and coefficients, summed through an adder tree.
// ----------------------------------------------------------------------------
module spf8_dot (
   input  spf8_pkg::tap_arr_type  taps,
   input  spf8_pkg::coef_arr_type coef,
   output spf8_pkg::acc_type      acc
);

   logic signed [spf8_pkg::PROD_W-1:0] prod [spf8_pkg::NUM_TAPS];
   spf8_pkg::acc_type lvl1 [spf8_pkg::NUM_TAPS/2];
   spf8_pkg::acc_type lvl2 [spf8_pkg::NUM_TAPS/4];

   always_comb begin
      for (int i = 0; i < spf8_pkg::NUM_TAPS; i++) begin
         prod[i] = spf8_pkg::PROD_W'(taps[i]) * spf8_pkg::PROD_W'(coef[i]);
      end
      for (int i = 0; i < spf8_pkg::NUM_TAPS/2; i++) begin
         lvl1[i] = spf8_pkg::ACC_W'(prod[2*i]) + spf8_pkg::ACC_W'(prod[2*i+1]);
      end
      for (int i = 0; i < spf8_pkg::NUM_TAPS/4; i++) begin
         lvl2[i] = lvl1[2*i] + lvl1[2*i+1];
      end
   end

   assign acc = lvl2[0] + lvl2[1];

endmodule

// File: rtl/core/spf8_post.sv
// ----------------------------------------------------------------------------
// spf8_post: offset, shift and clip
// Selects the pass-dependent rounding of the filter sum or of the bypassed centre tap.
// ----------------------------------------------------------------------------
module spf8_post #(
   parameter int FILTER_PREC   = spf8_pkg::FILTER_PREC_DEF,
   parameter int INTERNAL_PREC = spf8_pkg::INTERNAL_PREC_DEF
) (
   input  spf8_pkg::acc_type   acc,
   input  spf8_pkg::tap_type   center,
   input  spf8_pkg::flags_type flags,
   output spf8_pkg::out_type   filtered
);

   localparam int SW     = spf8_pkg::SUM_W;
   localparam int HEAD   = INTERNAL_PREC - spf8_pkg::PIX_BITS;
   localparam int OFFS   = 1 << (INTERNAL_PREC - 1);
   localparam int KF     = FILTER_PREC - HEAD;
   localparam int KF_POS = (KF >= 0) ? KF : 0;
   localparam int KF_NEG = (KF < 0) ? -KF : 0;
   localparam int KL     = FILTER_PREC + HEAD;

   localparam spf8_pkg::sum_type OFFS_W = SW'(OFFS);
   localparam spf8_pkg::sum_type RND_FL = SW'(1) << (FILTER_PREC - 1);
   localparam spf8_pkg::sum_type RND_L  = (SW'(1) << (KL - 1)) + (SW'(OFFS) << FILTER_PREC);
   localparam spf8_pkg::sum_type RND_B  = SW'(OFFS) + (SW'(1) << (HEAD - 1));

   spf8_pkg::sum_type s_ext;
   spf8_pkg::sum_type c_ext;
   spf8_pkg::sum_type f_first_last;
   spf8_pkg::sum_type f_last;
   spf8_pkg::sum_type f_first;
   spf8_pkg::sum_type f_plain;
   spf8_pkg::sum_type b_first;
   spf8_pkg::sum_type b_last;

   assign s_ext = SW'(acc);
   assign c_ext = SW'(center);

   assign f_first_last = (s_ext + RND_FL) >>> FILTER_PREC;
   assign f_last       = (s_ext + RND_L) >>> KL;
   assign f_first      = ((s_ext >>> KF_POS) <<< KF_NEG) - OFFS_W;
   assign f_plain      = s_ext >>> FILTER_PREC;
   assign b_first      = (c_ext <<< HEAD) - OFFS_W;
   assign b_last       = (c_ext + RND_B) >>> HEAD;

   always_comb begin
      if (flags.bypass) begin
         if (flags.is_first == flags.is_last) begin
            filtered = center;
         end else if (flags.is_first) begin
            filtered = b_first[spf8_pkg::OUT_W-1:0];
         end else begin
            filtered = spf8_pkg::clip_pix(b_last);
         end
      end else if (flags.is_last) begin
         if (flags.is_first) begin
            filtered = spf8_pkg::clip_pix(f_first_last);
         end else begin
            filtered = spf8_pkg::clip_pix(f_last);
         end
      end else if (flags.is_first) begin
         filtered = f_first[spf8_pkg::OUT_W-1:0];
      end else begin
         filtered = f_plain[spf8_pkg::OUT_W-1:0];
      end
   end

endmodule

// File: rtl/core/subpel_interp_fir_8tap.sv
// ----------------------------------------------------------------------------
// subpel_interp_fir_8tap: 8-tap luma sub-pel interpolation filter
// Input register, dot product with pass-dependent rounding, result register.
// ----------------------------------------------------------------------------
// Takes one item per clock while the response side does not stall and returns one
// filtered sample per item: the item is captured in the input register, the eight
// products, adder tree and offset/shift/clip settle combinationally, and the result
// is captured in the output register and held there until taken. The request
// side keeps accepting while a result waits, as long as the input register can
// move on or is empty. Coefficients are to be written through the register port
// only while no item is in flight; the block itself does not enforce this.
module subpel_interp_fir_8tap #(
   parameter int FILTER_PREC   = spf8_pkg::FILTER_PREC_DEF,
   parameter int INTERNAL_PREC = spf8_pkg::INTERNAL_PREC_DEF
) (
   input  logic         clock,
   input  logic         reset,
   spf8_req_intf.sink   req_port,
   spf8_rsp_intf.source rsp_port,
   spf8_csr_intf.sink   csr_port
);

   spf8_pkg::coef_arr_type coef;
   spf8_pkg::acc_type      acc;
   spf8_pkg::out_type      filtered_c;

   logic                  s1_valid_ff, s1_valid_in;
   spf8_pkg::tap_arr_type s1_taps_ff;
   spf8_pkg::flags_type   s1_flags_ff;
   logic                  out_valid_ff, out_valid_in;
   spf8_pkg::out_type     out_data_ff;

   logic s1_ready;
   logic s2_ready;

   spf8_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_port (csr_port),
      .coef     (coef)
   );

   spf8_dot u_dot (
      .taps (s1_taps_ff),
      .coef (coef),
      .acc  (acc)
   );

   spf8_post #(
      .FILTER_PREC   (FILTER_PREC),
      .INTERNAL_PREC (INTERNAL_PREC)
   ) u_post (
      .acc      (acc),
      .center   (s1_taps_ff[3]),
      .flags    (s1_flags_ff),
      .filtered (filtered_c)
   );

   assign s2_ready = !out_valid_ff || rsp_port.ready;
   assign s1_ready = !s1_valid_ff || s2_ready;

   assign s1_valid_in  = s1_ready ? req_port.valid : s1_valid_ff;
   assign out_valid_in = s2_ready ? s1_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_port.valid && s1_ready) begin
         s1_taps_ff[0]        <= req_port.tap_0;
         s1_taps_ff[1]        <= req_port.tap_1;
         s1_taps_ff[2]        <= req_port.tap_2;
         s1_taps_ff[3]        <= req_port.tap_3;
         s1_taps_ff[4]        <= req_port.tap_4;
         s1_taps_ff[5]        <= req_port.tap_5;
         s1_taps_ff[6]        <= req_port.tap_6;
         s1_taps_ff[7]        <= req_port.tap_7;
         s1_flags_ff.is_first <= req_port.is_first;
         s1_flags_ff.is_last  <= req_port.is_last;
         s1_flags_ff.bypass   <= req_port.bypass;
      end
      if (s1_valid_ff && s2_ready) begin
         out_data_ff <= filtered_c;
      end
   end

   assign req_port.ready    = s1_ready;
   assign rsp_port.valid    = out_valid_ff;
   assign rsp_port.filtered = out_data_ff;

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !out_valid_ff && !s1_valid_ff)
      else $error("pipeline not empty after reset");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_ready) |=> out_valid_ff)
      else $error("item lost between input and result register");

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_port.ready) |=> out_valid_ff && $stable(out_data_ff))
      else $error("stalled result changed");

   a_pixel_range: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_ready && s1_flags_ff.is_last
         && (!s1_flags_ff.bypass || !s1_flags_ff.is_first))
      |=> out_data_ff[spf8_pkg::OUT_W-1:spf8_pkg::PIX_BITS] == '0)
      else $error("last-pass result outside pixel range");

endmodule
